/* hdl/tasr_pkg.sv */
// Shared constants, register codes and types of the tensor reduction core.
`timescale 1ns / 1ps
package tasr_pkg;

   localparam int ACC_DEPTH_DEF = 16384;
   localparam int MAX_DIM_DEF   = 4096;
   localparam int ACC_WIDTH_DEF = 48;

   localparam int IN_BITS       = 16;
   localparam int OUT_BITS      = 48;
   localparam int DIM_BITS      = 13;
   localparam int SCALE_BITS    = 17;
   localparam int SCALE_FRAC    = 16;
   localparam logic [SCALE_BITS-1:0] SCALE_ONE = 17'h10000;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;

   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MEAN_MODE   = 3'd0,
      CSR_KEEP_DIMS   = 3'd1,
      CSR_REDUCE_AXIS = 3'd2,
      CSR_DIM_N       = 3'd3,
      CSR_DIM_H       = 3'd4,
      CSR_DIM_W       = 3'd5,
      CSR_DIM_C       = 3'd6,
      CSR_MEAN_SCALE  = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      AXIS_N = 2'd0,
      AXIS_C = 2'd1,
      AXIS_H = 2'd2,
      AXIS_W = 2'd3
   } axis_type;

   typedef struct packed {
      logic                  mean_mode;
      logic                  keep_dims;
      axis_type              reduce_axis;
      logic [DIM_BITS-1:0]   dim_n;
      logic [DIM_BITS-1:0]   dim_h;
      logic [DIM_BITS-1:0]   dim_w;
      logic [DIM_BITS-1:0]   dim_c;
      logic [SCALE_BITS-1:0] mean_scale;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mean_mode:   1'b0,
      keep_dims:   1'b1,
      reduce_axis: AXIS_N,
      dim_n:       13'd1,
      dim_h:       13'd1,
      dim_w:       13'd1,
      dim_c:       13'd1,
      mean_scale:  SCALE_ONE
   };

   // Status that travels with a value down the result pipeline.
   typedef struct packed {
      logic valid;
      logic ov;
      logic last;
   } tag_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] value;
      logic                       saturated;
      logic                       last;
   } rsp_type;

endpackage

/* hdl/tasr_ifs.sv */
// Valid/ready channel interfaces for request, response and register writes.
`timescale 1ns / 1ps
interface tasr_req_if;
   import tasr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [IN_BITS-1:0] sample_value;
   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface tasr_rsp_if;
   import tasr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] reduced_value;
   logic                       saturated;
   logic                       last_result;
   modport source (output valid, output reduced_value, output saturated, output last_result,
                   input ready);
   modport sink (input valid, input reduced_value, input saturated, input last_result,
                 output ready);
endinterface

interface tasr_csr_if;
   import tasr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/tasr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module tasr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tasr_csr.sv */
// Configuration registers; any write restarts the tensor.
`timescale 1ns / 1ps
module tasr_csr (
   input  logic              clock,
   input  logic              reset,
   tasr_csr_if.sink          csr_ch,
   output tasr_pkg::cfg_type cfg,
   output logic              restart
);
   import tasr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   assign csr_ch.ready = 1'b1;
   assign wr           = csr_ch.valid & csr_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_MEAN_MODE:   cfg_in.mean_mode   = csr_ch.data[0];
            CSR_KEEP_DIMS:   cfg_in.keep_dims   = csr_ch.data[0];
            CSR_REDUCE_AXIS: cfg_in.reduce_axis = axis_type'(csr_ch.data[1:0]);
            CSR_DIM_N:       cfg_in.dim_n       = csr_ch.data[DIM_BITS-1:0];
            CSR_DIM_H:       cfg_in.dim_h       = csr_ch.data[DIM_BITS-1:0];
            CSR_DIM_W:       cfg_in.dim_w       = csr_ch.data[DIM_BITS-1:0];
            CSR_DIM_C:       cfg_in.dim_c       = csr_ch.data[DIM_BITS-1:0];
            CSR_MEAN_SCALE:  cfg_in.mean_scale  = csr_ch.data[SCALE_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg     = cfg_ff;
   assign restart = wr;

endmodule

/* hdl/tasr_accum.sv */
// Position counters and the read-modify-write loop over the partial-sum RAM.
`timescale 1ns / 1ps
module tasr_accum #(
   parameter int ACC_DEPTH = tasr_pkg::ACC_DEPTH_DEF,
   parameter int MAX_DIM   = tasr_pkg::MAX_DIM_DEF,
   parameter int ACC_WIDTH = tasr_pkg::ACC_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tasr_pkg::cfg_type                 cfg,
   input  logic                              restart,
   input  logic                              in_accept,
   input  logic signed [tasr_pkg::IN_BITS-1:0] in_value,
   output tasr_pkg::tag_type                 out_tag,
   output logic signed [ACC_WIDTH-1:0]       out_acc,
   output logic [1:0]                        pend
);
   import tasr_pkg::*;

   localparam int CW = $clog2(MAX_DIM);
   localparam int AW = $clog2(ACC_DEPTH);
   localparam int RW = ACC_WIDTH + 1;

   function automatic logic [CW-1:0] dim_last(input logic [DIM_BITS-1:0] raw);
      logic [CW-1:0] r;
      if (raw == '0) begin
         r = '0;
      end else if (32'(raw) > MAX_DIM) begin
         r = CW'(MAX_DIM - 1);
      end else begin
         r = CW'(raw - 1'b1);
      end
      return r;
   endfunction

   logic [CW-1:0] last_n, last_h, last_w, last_c;
   logic [CW-1:0] n_ff, h_ff, w_ff, c_ff;
   logic [CW-1:0] n_in, h_in, w_in, c_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          end_n, end_h, end_w, end_c, tensor_last;
   logic          first, done, use_slot, slot_wrap;

   // Stage one: the element whose partial sum is being read this cycle.
   logic                      s1_valid_ff;
   logic                      s1_first_ff, s1_done_ff, s1_last_ff, s1_use_slot_ff;
   logic [AW-1:0]             s1_slot_ff;
   logic signed [IN_BITS-1:0] s1_x_ff;

   logic [RW-1:0]                rd_data;
   logic                         fwd_valid_ff;
   logic [AW-1:0]                fwd_addr_ff;
   logic [RW-1:0]                fwd_data_ff;
   logic                         fwd_hit;
   logic signed [ACC_WIDTH-1:0]  base_acc;
   logic                         base_ov;
   logic signed [ACC_WIDTH:0]    sum_ext;
   logic                         add_ov;
   logic signed [ACC_WIDTH-1:0]  acc;
   logic                         acc_ov;
   logic                         wr_en;

   logic signed [ACC_WIDTH-1:0]  run_acc_ff;
   logic                         run_ov_ff;

   tag_type                      out_tag_ff, out_tag_in;
   logic signed [ACC_WIDTH-1:0]  out_acc_ff;

   assign last_n = dim_last(cfg.dim_n);
   assign last_h = dim_last(cfg.dim_h);
   assign last_w = dim_last(cfg.dim_w);
   assign last_c = dim_last(cfg.dim_c);

   always_comb begin
      end_n       = n_ff == last_n;
      end_h       = h_ff == last_h;
      end_w       = w_ff == last_w;
      end_c       = c_ff == last_c;
      tensor_last = end_n & end_h & end_w & end_c;
      use_slot    = 1'b0;
      slot_wrap   = 1'b1;
      first       = (n_ff | h_ff | w_ff | c_ff) == '0;
      done        = tensor_last;
      if (cfg.keep_dims) begin
         unique case (cfg.reduce_axis)
            AXIS_C: begin
               first = c_ff == '0;
               done  = end_c;
            end
            AXIS_N: begin
               first     = n_ff == '0;
               done      = end_n;
               use_slot  = 1'b1;
               slot_wrap = end_h & end_w & end_c;
            end
            AXIS_H: begin
               first     = h_ff == '0;
               done      = end_h;
               use_slot  = 1'b1;
               slot_wrap = end_w & end_c;
            end
            AXIS_W: begin
               first     = w_ff == '0;
               done      = end_w;
               use_slot  = 1'b1;
               slot_wrap = end_c;
            end
         endcase
      end
   end

   // The slot index advances by one per element and restarts each time the
   // reduced axis index advances: the flattened index below that axis modulo depth.
   always_comb begin
      n_in    = n_ff;
      h_in    = h_ff;
      w_in    = w_ff;
      c_in    = c_ff;
      slot_in = slot_ff;
      if (restart) begin
         n_in    = '0;
         h_in    = '0;
         w_in    = '0;
         c_in    = '0;
         slot_in = '0;
      end else if (in_accept) begin
         if (!end_c) begin
            c_in = c_ff + 1'b1;
         end else begin
            c_in = '0;
            if (!end_w) begin
               w_in = w_ff + 1'b1;
            end else begin
               w_in = '0;
               if (!end_h) begin
                  h_in = h_ff + 1'b1;
               end else begin
                  h_in = '0;
                  n_in = end_n ? '0 : n_ff + 1'b1;
               end
            end
         end
         if (slot_wrap || slot_ff == AW'(ACC_DEPTH - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= '0;
         h_ff    <= '0;
         w_ff    <= '0;
         c_ff    <= '0;
         slot_ff <= '0;
      end else begin
         n_ff    <= n_in;
         h_ff    <= h_in;
         w_ff    <= w_in;
         c_ff    <= c_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_accept;
      end
      if (in_accept) begin
         s1_first_ff    <= first;
         s1_done_ff     <= done;
         s1_last_ff     <= tensor_last;
         s1_use_slot_ff <= use_slot;
         s1_slot_ff     <= slot_ff;
         s1_x_ff        <= in_value;
      end
   end

   assign wr_en = s1_valid_ff & s1_use_slot_ff;

   tasr_ram #(
      .WIDTH (RW),
      .DEPTH (ACC_DEPTH)
   ) u_partial_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data ({acc_ov, acc}),
      .rd_en   (in_accept),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // The RAM returns old data when the previous element writes the same slot
   // in the cycle of this element's read, so that write is forwarded.
   assign fwd_hit = fwd_valid_ff && (fwd_addr_ff == s1_slot_ff);

   always_comb begin
      if (s1_first_ff) begin
         base_acc = '0;
         base_ov  = 1'b0;
      end else if (s1_use_slot_ff) begin
         base_acc = fwd_hit ? fwd_data_ff[ACC_WIDTH-1:0] : rd_data[ACC_WIDTH-1:0];
         base_ov  = fwd_hit ? fwd_data_ff[ACC_WIDTH] : rd_data[ACC_WIDTH];
      end else begin
         base_acc = run_acc_ff;
         base_ov  = run_ov_ff;
      end
      sum_ext = (ACC_WIDTH + 1)'(base_acc) + (ACC_WIDTH + 1)'(s1_x_ff);
      add_ov  = sum_ext[ACC_WIDTH] != sum_ext[ACC_WIDTH-1];
      if (add_ov) begin
         acc = sum_ext[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                                  : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
      end else begin
         acc = sum_ext[ACC_WIDTH-1:0];
      end
      acc_ov = base_ov | add_ov;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_slot_ff;
         fwd_data_ff <= {acc_ov, acc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         run_acc_ff <= '0;
         run_ov_ff  <= 1'b0;
      end else if (s1_valid_ff && s1_last_ff) begin
         run_acc_ff <= '0;
         run_ov_ff  <= 1'b0;
      end else if (s1_valid_ff && !s1_use_slot_ff) begin
         run_acc_ff <= acc;
         run_ov_ff  <= acc_ov;
      end
   end

   always_comb begin
      out_tag_in.valid = s1_valid_ff & s1_done_ff;
      out_tag_in.ov    = acc_ov;
      out_tag_in.last  = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_tag_ff <= '0;
      end else begin
         out_tag_ff <= out_tag_in;
      end
      out_acc_ff <= acc;
   end

   assign out_tag = out_tag_ff;
   assign out_acc = out_acc_ff;
   assign pend    = {out_tag_in.valid, out_tag_ff.valid};

   fwd_tracks_write_a: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> fwd_valid_ff && fwd_addr_ff == $past(s1_slot_ff))
      else $error("forwarding register missed a partial-sum write");

   slot_in_range_a: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < ACC_DEPTH)
      else $error("slot index beyond partial-sum depth");

   counters_in_range_a: assert property (@(posedge clock) disable iff (reset)
      n_ff <= last_n && h_ff <= last_h && w_ff <= last_w && c_ff <= last_c)
      else $error("position counter beyond its dimension");

   running_cleared_a: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |=> run_acc_ff == '0 && !run_ov_ff)
      else $error("running total not cleared after the last element");

endmodule

/* hdl/tasr_scale.sv */
// Mean scaling by the reciprocal register, rounding and 48-bit output clamp.
`timescale 1ns / 1ps
module tasr_scale #(
   parameter int ACC_WIDTH = tasr_pkg::ACC_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tasr_pkg::tag_type                     in_tag,
   input  logic signed [ACC_WIDTH-1:0]           in_acc,
   input  logic                                  mean_mode,
   input  logic [tasr_pkg::SCALE_BITS-1:0]       mean_scale,
   output tasr_pkg::tag_type                     out_tag,
   output logic signed [tasr_pkg::OUT_BITS-1:0]  out_value,
   output logic [3:0]                            pend
);
   import tasr_pkg::*;

   localparam int LO_W = ACC_WIDTH / 2;
   localparam int HI_W = ACC_WIDTH - LO_W;
   localparam int PW   = ACC_WIDTH + SCALE_BITS;
   localparam int EW   = ((ACC_WIDTH > OUT_BITS) ? ACC_WIDTH : OUT_BITS) + 1;

   // Stage a: sign and magnitude.
   tag_type                a_tag_ff;
   logic                   a_neg_ff, a_mean_ff;
   logic [ACC_WIDTH-1:0]   a_mag_ff;
   logic [SCALE_BITS-1:0]  a_scale_ff;

   // Stage b: two partial products of the magnitude.
   tag_type                      b_tag_ff;
   logic                         b_neg_ff, b_mean_ff;
   logic [ACC_WIDTH-1:0]         b_mag_ff;
   logic [LO_W+SCALE_BITS-1:0]   b_pp_lo_ff;
   logic [HI_W+SCALE_BITS-1:0]   b_pp_hi_ff;

   // Stage c: rounded magnitude.
   tag_type                c_tag_ff;
   logic                   c_neg_ff;
   logic [ACC_WIDTH-1:0]   c_mag_ff;
   logic [PW-1:0]          prod;
   logic [ACC_WIDTH-1:0]   c_mag_in;

   // Stage d: clamped, signed result.
   tag_type                    d_tag_ff, d_tag_in;
   logic signed [OUT_BITS-1:0] d_value_ff;
   logic [EW-1:0]              r_ext, lim, mag_o, val;
   logic                       sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
         d_tag_ff <= '0;
      end else begin
         a_tag_ff <= in_tag;
         b_tag_ff <= a_tag_ff;
         c_tag_ff <= b_tag_ff;
         d_tag_ff <= d_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      a_neg_ff   <= in_acc[ACC_WIDTH-1];
      a_mag_ff   <= in_acc[ACC_WIDTH-1] ? ACC_WIDTH'(-in_acc) : ACC_WIDTH'(in_acc);
      a_mean_ff  <= mean_mode;
      a_scale_ff <= (mean_scale > SCALE_ONE) ? SCALE_ONE : mean_scale;
   end

   always_ff @(posedge clock) begin
      b_neg_ff   <= a_neg_ff;
      b_mean_ff  <= a_mean_ff;
      b_mag_ff   <= a_mag_ff;
      b_pp_lo_ff <= (LO_W + SCALE_BITS)'(a_mag_ff[LO_W-1:0])
                  * (LO_W + SCALE_BITS)'(a_scale_ff);
      b_pp_hi_ff <= (HI_W + SCALE_BITS)'(a_mag_ff[ACC_WIDTH-1:LO_W])
                  * (HI_W + SCALE_BITS)'(a_scale_ff);
   end

   // Round half away from zero on the magnitude; a scale of at most one
   // keeps the result no larger than the magnitude.
   always_comb begin
      prod = (PW'(b_pp_hi_ff) << LO_W) + PW'(b_pp_lo_ff)
           + (PW'(1) << (SCALE_FRAC - 1));
      c_mag_in = b_mean_ff ? prod[ACC_WIDTH+SCALE_FRAC-1:SCALE_FRAC] : b_mag_ff;
   end

   always_ff @(posedge clock) begin
      c_neg_ff <= b_neg_ff;
      c_mag_ff <= c_mag_in;
   end

   always_comb begin
      r_ext = EW'(c_mag_ff);
      lim   = (EW'(1) << (OUT_BITS - 1)) - EW'(!c_neg_ff);
      sat   = r_ext > lim;
      mag_o = sat ? lim : r_ext;
      val   = c_neg_ff ? (EW'(0) - mag_o) : mag_o;
      d_tag_in    = c_tag_ff;
      d_tag_in.ov = c_tag_ff.ov | sat;
   end

   always_ff @(posedge clock) begin
      d_value_ff <= val[OUT_BITS-1:0];
   end

   assign out_tag   = d_tag_ff;
   assign out_value = d_value_ff;
   assign pend      = {a_tag_ff.valid, b_tag_ff.valid, c_tag_ff.valid, d_tag_ff.valid};

endmodule

/* hdl/tasr_out_fifo.sv */
// Response queue that decouples the result pipeline from the response channel.
`timescale 1ns / 1ps
module tasr_out_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  tasr_pkg::rsp_type                   push_data,
   input  logic                                pop,
   output logic                                out_valid,
   output tasr_pkg::rsp_type                   head_data,
   output logic [tasr_pkg::FIFO_CNT_BITS-1:0]  count
);
   import tasr_pkg::*;

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);

   rsp_type                  entries_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign head_data = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* hdl/tensor_axis_sum_mean_reduce_core.sv */
// Top level of the streaming tensor sum/mean reduction core. Elements arrive
// in N,H,W,C order and the core accepts one request per clock cycle for as
// long as responses are taken; the figure is set by the read-modify-write of
// the partial-sum RAM, which is read at the accepting edge, written back at
// the next edge through its separate write port, and whose back-to-back
// same-slot case is forwarded. The request channel stalls while eight results
// are in flight or queued. The result that an accepted request completes is
// registered in turn by the add, sign and magnitude, multiply, rounding, clamp
// and response queue steps before it is valid on the response channel.
// The partial-sum RAM is not cleared after reset; each slot is written by the
// first element of its reduction before it is read. Any register write
// restarts the tensor at its first element, and registers must be written
// only while no request is in flight.
`timescale 1ns / 1ps
module tensor_axis_sum_mean_reduce_core #(
   parameter int ACC_DEPTH = tasr_pkg::ACC_DEPTH_DEF,
   parameter int MAX_DIM   = tasr_pkg::MAX_DIM_DEF,
   parameter int ACC_WIDTH = tasr_pkg::ACC_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   tasr_req_if.sink   req_ch,
   tasr_rsp_if.source rsp_ch,
   tasr_csr_if.sink   csr_ch
);
   import tasr_pkg::*;

   localparam int OCC_BITS = FIFO_CNT_BITS + 1;

   cfg_type                     cfg;
   logic                        restart;
   logic                        req_accept;
   tag_type                     acc_tag;
   logic signed [ACC_WIDTH-1:0] acc_value;
   logic [1:0]                  acc_pend;
   tag_type                     scl_tag;
   logic signed [OUT_BITS-1:0]  scl_value;
   logic [3:0]                  scl_pend;
   rsp_type                     push_data;
   rsp_type                     fifo_data;
   logic                        fifo_valid;
   logic                        fifo_pop;
   logic [FIFO_CNT_BITS-1:0]    fifo_count;
   logic [OCC_BITS-1:0]         occupancy;

   tasr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .cfg     (cfg),
      .restart (restart)
   );

   // Every response in flight holds a queue entry, so the queue never overflows.
   assign occupancy = OCC_BITS'(fifo_count)
                    + OCC_BITS'(acc_pend[0]) + OCC_BITS'(acc_pend[1])
                    + OCC_BITS'(scl_pend[0]) + OCC_BITS'(scl_pend[1])
                    + OCC_BITS'(scl_pend[2]) + OCC_BITS'(scl_pend[3]);

   assign req_ch.ready = occupancy < OCC_BITS'(FIFO_DEPTH);
   assign req_accept   = req_ch.valid & req_ch.ready;

   tasr_accum #(
      .ACC_DEPTH (ACC_DEPTH),
      .MAX_DIM   (MAX_DIM),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .restart   (restart),
      .in_accept (req_accept),
      .in_value  (req_ch.sample_value),
      .out_tag   (acc_tag),
      .out_acc   (acc_value),
      .pend      (acc_pend)
   );

   tasr_scale #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_tag     (acc_tag),
      .in_acc     (acc_value),
      .mean_mode  (cfg.mean_mode),
      .mean_scale (cfg.mean_scale),
      .out_tag    (scl_tag),
      .out_value  (scl_value),
      .pend       (scl_pend)
   );

   always_comb begin
      push_data.value     = scl_value;
      push_data.saturated = scl_tag.ov;
      push_data.last      = scl_tag.last;
   end

   assign fifo_pop = fifo_valid & rsp_ch.ready;

   tasr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (scl_tag.valid),
      .push_data (push_data),
      .pop       (fifo_pop),
      .out_valid (fifo_valid),
      .head_data (fifo_data),
      .count     (fifo_count)
   );

   assign rsp_ch.valid         = fifo_valid;
   assign rsp_ch.reduced_value = fifo_data.value;
   assign rsp_ch.saturated     = fifo_data.saturated;
   assign rsp_ch.last_result   = fifo_data.last;

endmodule
